>>> design/saob_pkg.sv
package saob_pkg;

    localparam int unsigned C_LANES      = 4;   // red, green, blue, alpha
    localparam int unsigned C_COLOURS    = 3;
    localparam int unsigned C_CH_W       = 8;
    localparam int unsigned C_NUM_W      = 24;
    localparam int unsigned C_DEN_W      = 16;
    localparam int unsigned C_DIV_STAGES = 4;
    localparam int unsigned C_DIV_BITS   = 2;   // quotient bits per divider stage
    localparam int unsigned C_ALPHA_LANE = 3;
    // prep stages, divider stages, output register
    localparam int unsigned C_PIPE_DEPTH = 2 + C_DIV_STAGES + 1;

    localparam logic [C_CH_W-1:0]  C_FULL     = 8'd255;
    localparam logic [C_DEN_W-1:0] C_DEN_ONE  = 16'd1;
    localparam logic [C_DEN_W-1:0] C_DEN_FULL = 16'd255;

    typedef struct packed {
        logic [C_CH_W-1:0] alpha;
        logic [C_CH_W-1:0] blue;
        logic [C_CH_W-1:0] green;
        logic [C_CH_W-1:0] red;
    } t_pixel;

    typedef enum logic [2:0] {
        CASE_KEEP,
        CASE_COPY,
        CASE_MIX,
        CASE_SPAN,
        CASE_COMP
    } t_case;

    // one pixel in flight through the divider
    typedef struct packed {
        logic [C_LANES-1:0][C_NUM_W-1:0] rem;
        logic [C_LANES-1:0][C_DEN_W-1:0] den;
        logic [C_LANES-1:0][C_CH_W-1:0]  quo;
        logic [C_CH_W-1:0]               offset;
        logic                            changed;
    } t_div_st;

endpackage

>>> design/straight_alpha_source_over_blend.sv
// pipeline: two preparation stages, four divider stages of two quotient bits each,
// one output register; throughput: one pixel per cycle while the output is not
// stalled; empty stages fill behind a stalled output
// reset (synchronous, active low) clears all stage valid bits and sets
// blend_rule to the per-pixel rule; o_stall is held high while in reset
module straight_alpha_source_over_blend (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    input  logic [7:0] i_dst_alpha,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha,
    output logic       o_changed
);

    logic              r_blend_rule;
    saob_pkg::t_pixel  w_src;
    saob_pkg::t_pixel  w_dst;
    saob_pkg::t_pixel  w_res;
    saob_pkg::t_div_st w_prep_word;
    saob_pkg::t_div_st w_div_word;
    logic              w_prep_ready;
    logic              w_prep_valid;
    logic              w_div_ready;
    logic              w_div_valid;
    logic              w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_rule <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_blend_rule <= i_cfg_wr_data;
        end
    end

    assign w_src = '{alpha: i_src_alpha, blue: i_src_blue, green: i_src_green, red: i_src_red};
    assign w_dst = '{alpha: i_dst_alpha, blue: i_dst_blue, green: i_dst_green, red: i_dst_red};

    assign o_stall = !w_prep_ready || !i_rst_n;

    saob_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blend_rule (r_blend_rule),
        .i_valid      (i_valid),
        .o_ready      (w_prep_ready),
        .i_src        (w_src),
        .i_dst        (w_dst),
        .o_valid      (w_prep_valid),
        .i_ready      (w_div_ready),
        .o_word       (w_prep_word)
    );

    saob_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_valid),
        .o_ready (w_div_ready),
        .i_word  (w_prep_word),
        .o_valid (w_div_valid),
        .i_ready (w_out_ready),
        .o_word  (w_div_word)
    );

    saob_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_div_valid),
        .o_ready   (w_out_ready),
        .i_word    (w_div_word),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_pixel   (w_res),
        .o_changed (o_changed)
    );

    assign o_out_red   = w_res.red;
    assign o_out_green = w_res.green;
    assign o_out_blue  = w_res.blue;
    assign o_out_alpha = w_res.alpha;

endmodule

>>> design/saob_prep.sv
module saob_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_blend_rule,
    input  logic             i_valid,
    output logic             o_ready,
    input  saob_pkg::t_pixel i_src,
    input  saob_pkg::t_pixel i_dst,
    output logic             o_valid,
    input  logic             i_ready,
    output saob_pkg::t_div_st o_word
);

    logic [saob_pkg::C_COLOURS-1:0][saob_pkg::C_CH_W-1:0] w_s;
    logic [saob_pkg::C_COLOURS-1:0][saob_pkg::C_CH_W-1:0] w_d;
    logic [saob_pkg::C_CH_W-1:0]                           w_inv;
    saob_pkg::t_case                                       w_case;

    logic [saob_pkg::C_COLOURS-1:0][2*saob_pkg::C_CH_W-1:0] r_sa;
    logic [saob_pkg::C_COLOURS-1:0][2*saob_pkg::C_CH_W-1:0] r_dm;
    logic [saob_pkg::C_COLOURS-1:0][saob_pkg::C_CH_W-1:0]   r_s;
    logic [saob_pkg::C_COLOURS-1:0][saob_pkg::C_CH_W-1:0]   r_d;
    logic [2*saob_pkg::C_CH_W-1:0]                          r_w;
    logic [saob_pkg::C_CH_W-1:0]                            r_a;
    logic [saob_pkg::C_CH_W-1:0]                            r_da;
    saob_pkg::t_case                                        r_case;
    logic                                                   r_va;

    saob_pkg::t_div_st n_word;
    saob_pkg::t_div_st r_word;
    logic              r_vb;

    logic w_rdy_a;
    logic w_rdy_b;

    logic [saob_pkg::C_NUM_W-1:0] w_mix [saob_pkg::C_COLOURS];
    logic [saob_pkg::C_NUM_W-1:0] w_comp [saob_pkg::C_COLOURS];
    logic [saob_pkg::C_DEN_W-1:0] w_n;

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_vb;
    assign o_word  = r_word;

    assign w_s   = {i_src.blue, i_src.green, i_src.red};
    assign w_d   = {i_dst.blue, i_dst.green, i_dst.red};
    assign w_inv = saob_pkg::C_FULL - i_src.alpha;

    always_comb begin
        if (i_src.alpha == '0) begin
            w_case = saob_pkg::CASE_KEEP;
        end else if (i_src.alpha == saob_pkg::C_FULL) begin
            w_case = saob_pkg::CASE_COPY;
        end else if (i_blend_rule) begin
            w_case = saob_pkg::CASE_SPAN;
        end else if (i_dst.alpha == saob_pkg::C_FULL) begin
            w_case = saob_pkg::CASE_MIX;
        end else begin
            w_case = saob_pkg::CASE_COMP;
        end
    end

    // stage a: the 8x8 products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_rdy_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            for (int i = 0; i < saob_pkg::C_COLOURS; i++) begin
                r_sa[i] <= w_s[i] * i_src.alpha;
                r_dm[i] <= w_d[i] * w_inv;
            end
            r_s    <= w_s;
            r_d    <= w_d;
            r_w    <= i_dst.alpha * w_inv;
            r_a    <= i_src.alpha;
            r_da   <= i_dst.alpha;
            r_case <= w_case;
        end
    end

    // stage b: numerators and divisors
    always_comb begin
        // n = a*255 + dst_alpha*(255-a)
        w_n = ({r_a, 8'd0} - {8'd0, r_a}) + r_w;
        for (int i = 0; i < saob_pkg::C_COLOURS; i++) begin
            w_mix[i]  = saob_pkg::C_NUM_W'(r_sa[i]) + saob_pkg::C_NUM_W'(r_dm[i]);
            w_comp[i] = ({r_sa[i], 8'd0} - {8'd0, r_sa[i]})
                      + (saob_pkg::C_NUM_W'(r_d[i]) * saob_pkg::C_NUM_W'(r_w));
        end

        n_word.quo     = '0;
        n_word.offset  = '0;
        n_word.changed = 1'b1;
        n_word.rem     = '0;
        n_word.den     = '0;

        case (r_case)
            saob_pkg::CASE_KEEP: begin
                for (int i = 0; i < saob_pkg::C_COLOURS; i++) begin
                    n_word.rem[i] = saob_pkg::C_NUM_W'(r_d[i]);
                    n_word.den[i] = saob_pkg::C_DEN_ONE;
                end
                n_word.rem[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_NUM_W'(r_da);
                n_word.den[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_DEN_ONE;
                n_word.changed = 1'b0;
            end
            saob_pkg::CASE_COPY: begin
                for (int i = 0; i < saob_pkg::C_COLOURS; i++) begin
                    n_word.rem[i] = saob_pkg::C_NUM_W'(r_s[i]);
                    n_word.den[i] = saob_pkg::C_DEN_ONE;
                end
                n_word.rem[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_NUM_W'(saob_pkg::C_FULL);
                n_word.den[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_DEN_ONE;
            end
            saob_pkg::CASE_MIX: begin
                for (int i = 0; i < saob_pkg::C_COLOURS; i++) begin
                    n_word.rem[i] = w_mix[i];
                    n_word.den[i] = saob_pkg::C_DEN_FULL;
                end
                n_word.rem[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_NUM_W'(saob_pkg::C_FULL);
                n_word.den[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_DEN_ONE;
            end
            saob_pkg::CASE_SPAN: begin
                for (int i = 0; i < saob_pkg::C_COLOURS; i++) begin
                    n_word.rem[i] = w_mix[i];
                    n_word.den[i] = saob_pkg::C_DEN_FULL;
                end
                n_word.rem[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_NUM_W'(r_w);
                n_word.den[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_DEN_FULL;
                n_word.offset = r_a;
            end
            saob_pkg::CASE_COMP: begin
                for (int i = 0; i < saob_pkg::C_COLOURS; i++) begin
                    n_word.rem[i] = w_comp[i];
                    n_word.den[i] = w_n;
                end
                n_word.rem[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_NUM_W'(w_n);
                n_word.den[saob_pkg::C_ALPHA_LANE] = saob_pkg::C_DEN_FULL;
            end
            default: begin
                n_word.changed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_rdy_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b) begin
            r_word <= n_word;
        end
    end

endmodule

>>> design/saob_div.sv
module saob_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  saob_pkg::t_div_st i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output saob_pkg::t_div_st o_word
);

    localparam int unsigned LAST = saob_pkg::C_DIV_STAGES - 1;

    saob_pkg::t_div_st                       r_st [saob_pkg::C_DIV_STAGES];
    saob_pkg::t_div_st                       n_st [saob_pkg::C_DIV_STAGES];
    logic [saob_pkg::C_DIV_STAGES-1:0]       r_v;
    logic [saob_pkg::C_DIV_STAGES-1:0]       w_rdy;

    // bubbles collapse: a stage takes a word when it is empty or moves on
    always_comb begin
        w_rdy[LAST] = !r_v[LAST] || i_ready;
        for (int j = LAST - 1; j >= 0; j--) begin
            w_rdy[j] = !r_v[j] || w_rdy[j+1];
        end
    end

    // restoring division, quotient bits from the top; quotient always fits 8 bits
    always_comb begin
        saob_pkg::t_div_st            st;
        logic [saob_pkg::C_NUM_W-1:0] dsh;
        int unsigned                  k;
        for (int j = 0; j < saob_pkg::C_DIV_STAGES; j++) begin
            if (j == 0) begin
                st = i_word;
            end else begin
                st = r_st[j-1];
            end
            for (int b = 0; b < saob_pkg::C_DIV_BITS; b++) begin
                k = saob_pkg::C_CH_W - 1 - j * saob_pkg::C_DIV_BITS - b;
                for (int l = 0; l < saob_pkg::C_LANES; l++) begin
                    dsh = saob_pkg::C_NUM_W'(st.den[l]) << k;
                    if (st.rem[l] >= dsh) begin
                        st.rem[l]    = st.rem[l] - dsh;
                        st.quo[l][k] = 1'b1;
                    end
                end
            end
            n_st[j] = st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < saob_pkg::C_DIV_STAGES; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= (j == 0) ? i_valid : r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < saob_pkg::C_DIV_STAGES; j++) begin
            if (w_rdy[j]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_word  = r_st[LAST];

endmodule

>>> design/saob_out.sv
module saob_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  saob_pkg::t_div_st i_word,
    output logic              o_valid,
    input  logic              i_stall,
    output saob_pkg::t_pixel  o_pixel,
    output logic              o_changed
);

    logic             w_rdy;
    saob_pkg::t_pixel n_pixel;
    saob_pkg::t_pixel r_pixel;
    logic             r_changed;
    logic             r_valid;

    assign w_rdy = !r_valid || !i_stall;

    // span alpha adds the source alpha back; never exceeds 255
    always_comb begin
        n_pixel.red   = i_word.quo[0];
        n_pixel.green = i_word.quo[1];
        n_pixel.blue  = i_word.quo[2];
        n_pixel.alpha = i_word.quo[saob_pkg::C_ALPHA_LANE] + i_word.offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_pixel   <= n_pixel;
            r_changed <= i_word.changed;
        end
    end

    assign o_ready   = w_rdy;
    assign o_valid   = r_valid;
    assign o_pixel   = r_pixel;
    assign o_changed = r_changed;

endmodule

>>> design/saob_checker.sv
module saob_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_alpha,
    input logic       o_changed
);

    logic [3:0] r_cnt;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // words inside the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 4'(w_in_acc) - 4'(w_out_acc);
        end
    end

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with an empty output");

    a_no_invented_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_cnt != 4'd0))
        else $error("result delivered with nothing in flight");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(saob_pkg::C_PIPE_DEPTH))
        else $error("more words in flight than stages");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_red)
            && $stable(o_out_alpha) && $stable(o_changed)))
        else $error("stalled result changed");

endmodule

bind straight_alpha_source_over_blend saob_checker u_saob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_red   (o_out_red),
    .o_out_alpha (o_out_alpha),
    .o_changed   (o_changed)
);

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OPAQUE       = 255;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PHASE_PIXELS = 100;
    localparam int unsigned REPORT_MAX   = 10;

    typedef enum logic {
        RULE_PIXEL = 1'b0,
        RULE_SPAN  = 1'b1
    } t_blend_rule;

    typedef enum int {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        saob_pkg::t_pixel pix;
        logic             changed;
    } t_blend_result;

    class blend_scoreboard;
        t_blend_rule   rule = RULE_PIXEL;
        t_blend_result expected_q[$];
        int unsigned   mismatches = 0;

        function automatic logic [7:0] mix_lane(int unsigned s, int unsigned d, int unsigned a);
            return 8'((s * a + d * (OPAQUE - a)) / OPAQUE);
        endfunction

        function automatic t_blend_result composite(saob_pkg::t_pixel src,
                                                    saob_pkg::t_pixel dst);
            int unsigned   a;
            int unsigned   da;
            int unsigned   w;
            int unsigned   n;
            t_blend_result res;
            a = src.alpha;
            da = dst.alpha;
            res.changed = 1'b1;
            if (a == 0) begin
                res.pix = dst;
                res.changed = 1'b0;
            end else if (a == OPAQUE) begin
                res.pix = src;
                res.pix.alpha = 8'(OPAQUE);
            end else if (rule == RULE_SPAN || da == OPAQUE) begin
                res.pix.red   = mix_lane(src.red, dst.red, a);
                res.pix.green = mix_lane(src.green, dst.green, a);
                res.pix.blue  = mix_lane(src.blue, dst.blue, a);
                if (rule == RULE_SPAN) begin
                    res.pix.alpha = 8'(a + (da * (OPAQUE - a)) / OPAQUE);
                end else begin
                    res.pix.alpha = 8'(OPAQUE);
                end
            end else begin
                // translucent destination: weight it by its own coverage
                w = da * (OPAQUE - a);
                n = a * OPAQUE + w;
                res.pix.red   = 8'((src.red * a * OPAQUE + dst.red * w) / n);
                res.pix.green = 8'((src.green * a * OPAQUE + dst.green * w) / n);
                res.pix.blue  = 8'((src.blue * a * OPAQUE + dst.blue * w) / n);
                res.pix.alpha = 8'(n / OPAQUE);
            end
            return res;
        endfunction

        function void note_pixel(saob_pkg::t_pixel src, saob_pkg::t_pixel dst);
            expected_q.insert(expected_q.size(), composite(src, dst));
        endfunction

        function void check_pixel(saob_pkg::t_pixel pix, logic changed);
            t_blend_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected word: r %0d g %0d b %0d a %0d changed %0d",
                             pix.red, pix.green, pix.blue, pix.alpha, changed);
                end
                return;
            end
            want = expected_q.pop_front();
            if (want.pix.red !== pix.red || want.pix.green !== pix.green ||
                    want.pix.blue !== pix.blue || want.pix.alpha !== pix.alpha ||
                    want.changed !== changed) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch: expected r %0d g %0d b %0d a %0d changed %0d,",
                             want.pix.red, want.pix.green, want.pix.blue,
                             want.pix.alpha, want.changed);
                    $display("          got      r %0d g %0d b %0d a %0d changed %0d",
                             pix.red, pix.green, pix.blue, pix.alpha, changed);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_src_red = '0;
    logic [7:0] i_src_green = '0;
    logic [7:0] i_src_blue = '0;
    logic [7:0] i_src_alpha = '0;
    logic [7:0] i_dst_red = '0;
    logic [7:0] i_dst_green = '0;
    logic [7:0] i_dst_blue = '0;
    logic [7:0] i_dst_alpha = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic [7:0] o_out_alpha;
    logic       o_changed;

    blend_scoreboard sb = new();
    t_idle_mode      idle_mode = IDLE_NONE;
    int unsigned     cycles = 0;

    straight_alpha_source_over_blend i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_src_red     (i_src_red),
        .i_src_green   (i_src_green),
        .i_src_blue    (i_src_blue),
        .i_src_alpha   (i_src_alpha),
        .i_dst_red     (i_dst_red),
        .i_dst_green   (i_dst_green),
        .i_dst_blue    (i_dst_blue),
        .i_dst_alpha   (i_dst_alpha),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .o_changed     (o_changed)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit source_waits();
        int unsigned pct;
        case (idle_mode)
            IDLE_SOURCE: pct = 77;
            IDLE_BOTH:   pct = 30;
            default:     pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sink_stalls();
        int unsigned pct;
        case (idle_mode)
            IDLE_SINK: pct = 77;
            IDLE_BOTH: pct = 30;
            default:   pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // output side: take the word seen at this edge, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_pixel('{alpha: o_out_alpha, blue: o_out_blue,
                             green: o_out_green, red: o_out_red}, o_changed);
        end
        i_stall <= sink_stalls();
    end

    task automatic send_pixel(input saob_pkg::t_pixel src, input saob_pkg::t_pixel dst);
        while (source_waits()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_src_red   <= src.red;
        i_src_green <= src.green;
        i_src_blue  <= src.blue;
        i_src_alpha <= src.alpha;
        i_dst_red   <= dst.red;
        i_dst_green <= dst.green;
        i_dst_blue  <= dst.blue;
        i_dst_alpha <= dst.alpha;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(src, dst);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (saob_pkg::C_PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_rule(input t_blend_rule r);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.rule = r;
    endtask

    function automatic logic [7:0] pick_alpha();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'd255;
        if (r < 28) return 8'd1;
        if (r < 35) return 8'd254;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_colour();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return 8'd0;
        if (r < 24) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic saob_pkg::t_pixel pick_pixel(bit is_dst);
        saob_pkg::t_pixel p;
        p.red   = pick_colour();
        p.green = pick_colour();
        p.blue  = pick_colour();
        p.alpha = (is_dst && $urandom_range(99) < 20) ? 8'd255 : pick_alpha();
        return p;
    endfunction

    task automatic send_corner_cases();
        // transparent source, opaque copy, both edges of the divisor range
        send_pixel('{alpha: 0,   blue: 255, green: 255, red: 255},
                   '{alpha: 78,  blue: 56,  green: 34,  red: 12});
        send_pixel('{alpha: 255, blue: 128, green: 0,   red: 255},
                   '{alpha: 0,   blue: 9,   green: 9,   red: 9});
        send_pixel('{alpha: 255, blue: 0,   green: 0,   red: 0},
                   '{alpha: 255, blue: 255, green: 255, red: 255});
        send_pixel('{alpha: 1,   blue: 255, green: 255, red: 255},
                   '{alpha: 0,   blue: 0,   green: 0,   red: 0});
        send_pixel('{alpha: 254, blue: 255, green: 255, red: 255},
                   '{alpha: 255, blue: 0,   green: 0,   red: 0});
        send_pixel('{alpha: 128, blue: 0,   green: 0,   red: 0},
                   '{alpha: 255, blue: 255, green: 255, red: 255});
        send_pixel('{alpha: 128, blue: 77,  green: 0,   red: 255},
                   '{alpha: 128, blue: 200, green: 255, red: 0});
        send_pixel('{alpha: 1,   blue: 255, green: 255, red: 255},
                   '{alpha: 254, blue: 255, green: 255, red: 255});
        send_pixel('{alpha: 254, blue: 3,   green: 200, red: 100},
                   '{alpha: 1,   blue: 250, green: 5,   red: 60});
        send_pixel('{alpha: 255, blue: 255, green: 255, red: 255},
                   '{alpha: 255, blue: 255, green: 255, red: 255});
        send_pixel('{alpha: 0,   blue: 0,   green: 0,   red: 0},
                   '{alpha: 0,   blue: 0,   green: 0,   red: 0});
        send_pixel('{alpha: 100, blue: 3,   green: 2,   red: 1},
                   '{alpha: 0,   blue: 255, green: 255, red: 255});
    endtask

    initial begin
        t_idle_mode phase_modes[4];
        phase_modes = '{IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_corner_cases();
        drain();
        write_rule(RULE_SPAN);
        send_corner_cases();
        drain();

        for (int p = 0; p < 8; p++) begin
            write_rule((p % 2 == 0) ? RULE_PIXEL : RULE_SPAN);
            idle_mode = phase_modes[p / 2];
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                send_pixel(pick_pixel(1'b0), pick_pixel(1'b1));
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
design/saob_pkg.sv
design/saob_prep.sv
design/saob_div.sv
design/saob_out.sv
design/straight_alpha_source_over_blend.sv
design/saob_checker.sv
bench/tb.sv
